>>> rtl/laplacian_edge_filter_stream_defines.svh
// ----------------------------------------------------------------------------
// laplacian edge filter assertion macros
// shared checks for the streaming laplacian filter, clocked on clk, off in rst
// ----------------------------------------------------------------------------
`ifndef LAPLACIAN_EDGE_FILTER_STREAM_DEFINES_SVH
`define LAPLACIAN_EDGE_FILTER_STREAM_DEFINES_SVH

// same-cycle implication
`define LEF_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define LEF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/lef_pkg.sv
// ----------------------------------------------------------------------------
// lef_pkg
// types, constants and stencil helpers for the laplacian edge filter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lef_pkg;

  localparam int MAX_LINE_WIDTH = 1024;
  localparam int STORED_LINES   = 7;
  localparam int MAX_USED_WIDTH = (MAX_LINE_WIDTH < 1024) ? MAX_LINE_WIDTH : 1024;
  localparam int MIN_DIM        = 4;

  localparam int PIX_W     = 8;
  localparam int COL_W     = $clog2(MAX_LINE_WIDTH);
  localparam int ROW_W     = 12;
  localparam int WIDTH_W   = 11;
  localparam int HEIGHT_W  = 12;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int SLOT_W    = $clog2(STORED_LINES);
  localparam int STENCIL_W = 12;
  localparam int SUM_W     = 13;

  localparam int BANK_DEPTH = (MAX_LINE_WIDTH + STORED_LINES - 1) / STORED_LINES;
  localparam int BANK_AW    = $clog2(BANK_DEPTH);

  localparam logic [WIDTH_W-1:0]  RESET_WIDTH  = WIDTH_W'(960);
  localparam logic [HEIGHT_W-1:0] RESET_HEIGHT = HEIGHT_W'(540);
  localparam int                  BIAS         = 128;
  localparam int                  PIX_MAX      = 255;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_LINE_WIDTH   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef logic [STORED_LINES-1:0][PIX_W-1:0] lef_word_t;

  typedef struct packed {
    logic              result;
    logic              last;
    logic [SLOT_W-1:0] slot;
    logic [SLOT_W-1:0] cr;
    logic              row_top;
    logic              row_bot;
    logic              col_left;
    logic              col_right;
  } lef_item_t;

  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  bank;
    logic [BANK_AW-1:0] addr;
    logic [SLOT_W-1:0]  slot;
    logic [PIX_W-1:0]   data;
  } lef_wr_t;

  function automatic logic [SLOT_W-1:0] lef_slot_add(input logic [SLOT_W-1:0] base,
                                                     input int step);
    int s;
    s = int'(base) + step + STORED_LINES;
    if (s >= STORED_LINES) s = s - STORED_LINES;
    if (s >= STORED_LINES) s = s - STORED_LINES;
    return SLOT_W'(s);
  endfunction

  function automatic logic signed [STENCIL_W-1:0] lef_one_sided(
      input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] n1,
      input logic [PIX_W-1:0] n2, input logic [PIX_W-1:0] n3);
    int r;
    r = 2 * int'(c) - 5 * int'(n1) + 4 * int'(n2) - int'(n3);
    return STENCIL_W'(r);
  endfunction

  function automatic logic signed [STENCIL_W-1:0] lef_central(
      input logic [PIX_W-1:0] a, input logic [PIX_W-1:0] c, input logic [PIX_W-1:0] b);
    int r;
    r = int'(a) - 2 * int'(c) + int'(b);
    return STENCIL_W'(r);
  endfunction

endpackage

`default_nettype wire

>>> rtl/lef_in_if.sv
// ----------------------------------------------------------------------------
// lef_in_if
// pixel input channel: valid, ready, op and pixel
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lef_in_if;
  import lef_pkg::*;
  logic             valid;
  logic             ready;
  logic             op;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output op, output pixel_in, input ready);
  modport sink   (input valid, input op, input pixel_in, output ready);
endinterface

`default_nettype wire

>>> rtl/lef_out_if.sv
// ----------------------------------------------------------------------------
// lef_out_if
// filtered pixel output channel: valid, ready, pixel and frame end
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface lef_out_if;
  import lef_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             frame_end;
  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

`default_nettype wire

>>> rtl/lef_line_bank.sv
// ----------------------------------------------------------------------------
// lef_line_bank
// one column bank of the line store, byte-lane write, registered read
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lef_line_bank #(
  parameter int DEPTH  = 147,
  parameter int AW     = 8,
  parameter int LANES  = 7,
  parameter int LANE_W = 8
) (
  input  wire logic                           clk,
  input  wire logic                           we,
  input  wire logic [AW-1:0]                  waddr,
  input  wire logic [$clog2(LANES)-1:0]       wlane,
  input  wire logic [LANE_W-1:0]              wdata,
  input  wire logic                           re,
  input  wire logic [AW-1:0]                  raddr,
  output logic      [LANES-1:0][LANE_W-1:0]   rdata
);

  logic [LANES-1:0][LANE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr][wlane] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/lef_ctrl.sv
// ----------------------------------------------------------------------------
// lef_ctrl
// registers, raster counters, output decision and line store addressing
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lef_ctrl (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire logic                                               cfg_we,
  input  wire logic [lef_pkg::CFG_IDX_W-1:0]                      cfg_index,
  input  wire logic [lef_pkg::CFG_W-1:0]                          cfg_data,
  input  wire logic                                               fire,
  input  wire logic                                               op,
  input  wire logic [lef_pkg::PIX_W-1:0]                          pixel_in,
  output lef_pkg::lef_item_t                                      item,
  output lef_pkg::lef_wr_t                                        wr,
  output logic [lef_pkg::STORED_LINES-1:0][lef_pkg::BANK_AW-1:0]  raddr,
  output logic                                                    frame_ahead
);
  import lef_pkg::*;

  localparam int LEAD_W = ROW_W + WIDTH_W + 4;

  logic [WIDTH_W-1:0]  line_width;
  logic [HEIGHT_W-1:0] frame_height;
  logic [COL_W-1:0]    in_column, out_column;
  logic [ROW_W-1:0]    in_row, out_row;
  logic [SLOT_W-1:0]   in_slot, out_slot, in_res, out_res;
  logic [BANK_AW-1:0]  in_quo, out_quo;
  logic                frame_ahead_next;

  logic [WIDTH_W-1:0]       w;
  logic [HEIGHT_W-1:0]      h;
  logic                     in_col_last, in_row_last, out_col_last, out_row_last;
  logic                     is_pixel, ahead_in, emit, last;
  logic signed [ROW_W+1:0]  row_gap;
  logic signed [LEAD_W-1:0] lead, need;

  always_comb begin
    if (line_width > WIDTH_W'(MAX_USED_WIDTH)) w = WIDTH_W'(MAX_USED_WIDTH);
    else if (line_width < WIDTH_W'(MIN_DIM))   w = WIDTH_W'(MIN_DIM);
    else                                       w = line_width;
    if (frame_height < HEIGHT_W'(MIN_DIM)) h = HEIGHT_W'(MIN_DIM);
    else                                   h = frame_height;
  end

  assign in_col_last  = (WIDTH_W'(in_column) + WIDTH_W'(1)) >= w;
  assign in_row_last  = ({1'b0, in_row} + (ROW_W + 1)'(1)) >= {1'b0, h};
  assign out_col_last = (WIDTH_W'(out_column) + WIDTH_W'(1)) >= w;
  assign out_row_last = ({1'b0, out_row} + (ROW_W + 1)'(1)) >= {1'b0, h};
  assign last         = out_col_last && out_row_last;

  // lead of input over output in pixels, less three lines
  assign row_gap = $signed({2'b00, in_row}) - $signed({2'b00, out_row}) - (ROW_W + 2)'(3);
  always_comb begin
    lead = LEAD_W'(row_gap) * $signed({{(LEAD_W - WIDTH_W){1'b0}}, w});
    if (in_col_last) lead = lead + $signed({{(LEAD_W - WIDTH_W){1'b0}}, w});
    else             lead = lead + $signed(LEAD_W'(in_column) + LEAD_W'(1));
    need = $signed(LEAD_W'(out_column) + LEAD_W'(4));
  end

  assign is_pixel = (op == OP_PIXEL);
  assign ahead_in = frame_ahead || (in_col_last && in_row_last);
  assign emit     = is_pixel ? (ahead_in || (lead >= need)) : frame_ahead;

  always_comb begin
    frame_ahead_next = is_pixel ? ahead_in : frame_ahead;
    if (emit && last) frame_ahead_next = 1'b0;
  end

  always_comb begin
    item.result    = fire && emit;
    item.last      = last;
    item.slot      = out_slot;
    item.cr        = out_res;
    item.row_top   = (out_row == '0);
    item.row_bot   = out_row_last;
    item.col_left  = (out_column == '0);
    item.col_right = out_col_last;
    wr.en          = fire && is_pixel;
    wr.bank        = in_res;
    wr.addr        = in_quo;
    wr.slot        = in_slot;
    wr.data        = pixel_in;
  end

  // bank b holds the window column congruent to b
  always_comb begin
    int d, k, t, a;
    for (int b = 0; b < STORED_LINES; b++) begin
      d = b - int'(out_res);
      if (d < 0) d = d + STORED_LINES;
      k = (d > 3) ? d - STORED_LINES : d;
      t = int'(out_res) + k;
      a = int'(out_quo);
      if (t >= STORED_LINES) a = a + 1;
      if (t < 0) a = a - 1;
      if (a < 0) a = 0;
      if (a > BANK_DEPTH - 1) a = BANK_DEPTH - 1;
      raddr[b] = BANK_AW'(a);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
      in_column    <= '0;
      in_row       <= '0;
      in_slot      <= '0;
      in_res       <= '0;
      in_quo       <= '0;
      out_column   <= '0;
      out_row      <= '0;
      out_slot     <= '0;
      out_res      <= '0;
      out_quo      <= '0;
      frame_ahead  <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_LINE_WIDTH:   line_width   <= cfg_data[WIDTH_W-1:0];
          CFG_FRAME_HEIGHT: frame_height <= cfg_data[HEIGHT_W-1:0];
          default: ;
        endcase
      end
      if (fire) begin
        frame_ahead <= frame_ahead_next;
        if (is_pixel) begin
          if (in_col_last) begin
            in_column <= '0;
            in_res    <= '0;
            in_quo    <= '0;
            in_slot   <= (in_slot == SLOT_W'(STORED_LINES - 1)) ? '0 : in_slot + 1'b1;
            in_row    <= in_row_last ? '0 : in_row + 1'b1;
          end else begin
            in_column <= in_column + 1'b1;
            if (in_res == SLOT_W'(STORED_LINES - 1)) begin
              in_res <= '0;
              in_quo <= in_quo + 1'b1;
            end else begin
              in_res <= in_res + 1'b1;
            end
          end
        end
        if (emit) begin
          if (out_col_last) begin
            out_column <= '0;
            out_res    <= '0;
            out_quo    <= '0;
            out_slot   <= (out_slot == SLOT_W'(STORED_LINES - 1)) ? '0 : out_slot + 1'b1;
            out_row    <= out_row_last ? '0 : out_row + 1'b1;
          end else begin
            out_column <= out_column + 1'b1;
            if (out_res == SLOT_W'(STORED_LINES - 1)) begin
              out_res <= '0;
              out_quo <= out_quo + 1'b1;
            end else begin
              out_res <= out_res + 1'b1;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/lef_stencil.sv
// ----------------------------------------------------------------------------
// lef_stencil
// write forwarding, tap selection, laplacian sum, clamp and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lef_stencil (
  input  wire logic                                               clk,
  input  wire logic                                               rst,
  input  wire logic                                               advance,
  input  lef_pkg::lef_item_t                                      item,
  input  lef_pkg::lef_wr_t                                        wr,
  input  wire logic [lef_pkg::STORED_LINES-1:0][lef_pkg::BANK_AW-1:0] raddr,
  input  lef_pkg::lef_word_t                                      rdata [lef_pkg::STORED_LINES],
  output logic                                                    s1_busy,
  output logic                                                    out_valid,
  output logic [lef_pkg::PIX_W-1:0]                               pixel_out,
  output logic                                                    frame_end
);
  import lef_pkg::*;

  lef_item_t                                s1_item;
  lef_wr_t                                  s1_wr;
  logic [STORED_LINES-1:0][BANK_AW-1:0]     s1_raddr;
  logic                                     s1_valid;

  lef_word_t                    merged [STORED_LINES];
  logic [PIX_W-1:0]             vtap [STORED_LINES];
  logic [PIX_W-1:0]             htap [STORED_LINES];
  logic signed [STENCIL_W-1:0]  vert, horz;
  logic signed [SUM_W-1:0]      sum;
  logic [PIX_W-1:0]             value;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      s1_valid  <= item.result;
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_item   <= item;
      s1_wr     <= wr;
      s1_raddr  <= raddr;
      pixel_out <= value;
      frame_end <= s1_item.last;
    end
  end

  assign s1_busy = s1_valid;

  // the pixel written with this read is not yet in the bank output
  always_comb begin
    for (int b = 0; b < STORED_LINES; b++) begin
      merged[b] = rdata[b];
      if (s1_wr.en && (s1_wr.bank == SLOT_W'(b)) && (s1_wr.addr == s1_raddr[b])) begin
        merged[b][s1_wr.slot] = s1_wr.data;
      end
    end
    for (int i = 0; i < STORED_LINES; i++) begin
      vtap[i] = merged[s1_item.cr][lef_slot_add(s1_item.slot, i - 3)];
      htap[i] = merged[lef_slot_add(s1_item.cr, i - 3)][s1_item.slot];
    end
  end

  always_comb begin
    priority if (s1_item.row_top) vert = lef_one_sided(vtap[3], vtap[4], vtap[5], vtap[6]);
    else if (s1_item.row_bot)     vert = lef_one_sided(vtap[3], vtap[2], vtap[1], vtap[0]);
    else                          vert = lef_central(vtap[2], vtap[3], vtap[4]);

    priority if (s1_item.col_left) horz = lef_one_sided(htap[3], htap[4], htap[5], htap[6]);
    else if (s1_item.col_right)    horz = lef_one_sided(htap[3], htap[2], htap[1], htap[0]);
    else                           horz = lef_central(htap[2], htap[3], htap[4]);

    sum = SUM_W'(vert) + SUM_W'(horz) + SUM_W'(BIAS);
    if (sum < 0)                    value = '0;
    else if (sum > SUM_W'(PIX_MAX)) value = PIX_W'(PIX_MAX);
    else                            value = sum[PIX_W-1:0];
  end

endmodule

`default_nettype wire

>>> rtl/laplacian_edge_filter_stream.sv
// ----------------------------------------------------------------------------
// laplacian_edge_filter_stream
// Streaming 4-neighbour laplacian on 8-bit grey pixels in raster order. The
// last seven lines sit in seven column banks (column mod 7), each word holding
// one byte per stored line, so a single read of all banks returns the whole
// 7x7 neighbourhood cross of the output pixel. One item is taken every clock
// while the output is not stalled; a result that an item releases leaves
// through the registered bank read and the stencil stage. Output trails input
// by three lines and three pixels; flush items (op = 1) drain the rest of a
// finished frame. Edge rows and columns use the one-sided inward stencil. The
// line store has no reset and needs no clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "laplacian_edge_filter_stream_defines.svh"

module laplacian_edge_filter_stream (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_we,
  input  wire logic [lef_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [lef_pkg::CFG_W-1:0]         cfg_data,
  lef_in_if.sink                                 pixels,
  lef_out_if.source                              edges
);
  import lef_pkg::*;

  logic                                 advance, fire, frame_ahead, s1_busy;
  lef_item_t                            item;
  lef_wr_t                              wr;
  logic [STORED_LINES-1:0][BANK_AW-1:0] raddr;
  lef_word_t                            rdata [STORED_LINES];

  assign advance      = !edges.valid || edges.ready;
  assign pixels.ready = advance;
  assign fire         = pixels.valid && advance;

  lef_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .fire,
    .op          (pixels.op),
    .pixel_in    (pixels.pixel_in),
    .item, .wr, .raddr, .frame_ahead
  );

  for (genvar b = 0; b < STORED_LINES; b++) begin : g_bank
    lef_line_bank #(
      .DEPTH  (BANK_DEPTH),
      .AW     (BANK_AW),
      .LANES  (STORED_LINES),
      .LANE_W (PIX_W)
    ) u_bank (
      .clk,
      .we    (wr.en && (wr.bank == SLOT_W'(b))),
      .waddr (wr.addr),
      .wlane (wr.slot),
      .wdata (wr.data),
      .re    (advance),
      .raddr (raddr[b]),
      .rdata (rdata[b])
    );
  end

  lef_stencil u_stencil (
    .clk, .rst, .advance, .item, .wr, .raddr, .rdata, .s1_busy,
    .out_valid (edges.valid),
    .pixel_out (edges.pixel_out),
    .frame_end (edges.frame_end)
  );

  `LEF_ASSERT(a_flush_waits, fire && pixels.op == OP_FLUSH && !frame_ahead, !item.result, "flush released a pixel before the frame was complete")
  `LEF_ASSERT(a_write_range, wr.en, wr.addr < BANK_AW'(BANK_DEPTH) && wr.bank < SLOT_W'(STORED_LINES), "line store write outside the banks")
  `LEF_ASSERT_NEXT(a_read_loaded, fire && item.result, s1_busy, "released pixel lost before the stencil stage")

endmodule

`default_nettype wire

>>> tb/sv/laplacian_edge_filter_stream_tb.sv
// ----------------------------------------------------------------------------
// laplacian_edge_filter_stream_tb
// Sends raster frames of grey pixels and flush items to the streaming
// laplacian filter, predicts every filtered pixel and frame end in a local
// line store model, and compares each output transfer in order. Covers
// clamping, edge stencils, size register extremes, flushes and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module laplacian_edge_filter_stream_tb;
  import lef_pkg::*;

  typedef struct {
    logic [PIX_W-1:0] pixel;
    logic             last;
  } edge_result_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  lef_in_if  pixels ();
  lef_out_if edges ();

  laplacian_edge_filter_stream dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .pixels(pixels), .edges(edges)
  );

  edge_result_t expected_edges[$];
  int fails;
  int cycles;
  bit idle_on;
  int stall_left;

  logic [PIX_W-1:0] shadow_lines[STORED_LINES * MAX_LINE_WIDTH];
  int in_col, in_rw, out_col, out_rw, in_sl, out_sl;
  bit ahead;
  int reg_width, reg_height;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int eff_width();
    int w;
    w = reg_width;
    if (w > MAX_LINE_WIDTH) w = MAX_LINE_WIDTH;
    if (w > 1024) w = 1024;
    if (w < 4) w = 4;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = reg_height;
    if (h > 4095) h = 4095;
    if (h < 4) h = 4;
    return h;
  endfunction

  function automatic int line_tap(int d, int col);
    int s;
    s = (out_sl + STORED_LINES + d) % STORED_LINES;
    return int'(shadow_lines[s * MAX_LINE_WIDTH + (col % MAX_LINE_WIDTH)]);
  endfunction

  function automatic int inward(int c, int n1, int n2, int n3);
    return 2 * c - 5 * n1 + 4 * n2 - n3;
  endfunction

  function automatic int laplacian_at(int w, int h);
    int ctr, v, hz, sum;
    ctr = line_tap(0, out_col);
    if (out_rw == 0)
      v = inward(ctr, line_tap(1, out_col), line_tap(2, out_col), line_tap(3, out_col));
    else if (out_rw + 1 >= h)
      v = inward(ctr, line_tap(-1, out_col), line_tap(-2, out_col), line_tap(-3, out_col));
    else
      v = line_tap(-1, out_col) - 2 * ctr + line_tap(1, out_col);
    if (out_col == 0)
      hz = inward(ctr, line_tap(0, 1), line_tap(0, 2), line_tap(0, 3));
    else if (out_col + 1 >= w)
      hz = inward(ctr, line_tap(0, out_col - 1), line_tap(0, out_col - 2),
                  line_tap(0, out_col - 3));
    else
      hz = line_tap(0, out_col - 1) - 2 * ctr + line_tap(0, out_col + 1);
    sum = v + hz + BIAS;
    if (sum < 0) sum = 0;
    if (sum > PIX_MAX) sum = PIX_MAX;
    return sum;
  endfunction

  function automatic void predict_edge(logic op, logic [PIX_W-1:0] pix);
    int w, h;
    bit emit;
    edge_result_t r;
    w = eff_width();
    h = eff_height();
    if (op == OP_PIXEL) begin
      shadow_lines[in_sl * MAX_LINE_WIDTH + (in_col % MAX_LINE_WIDTH)] = pix;
      if (in_col + 1 >= w) begin
        in_col = 0;
        in_sl = (in_sl + 1) % STORED_LINES;
        if (in_rw + 1 >= h) begin
          in_rw = 0;
          ahead = 1'b1;
        end else begin
          in_rw++;
        end
      end else begin
        in_col++;
      end
      emit = ahead || (in_rw * w + in_col >= out_rw * w + out_col + 3 * w + 4);
    end else begin
      emit = ahead;
    end
    if (!emit) return;
    r.pixel = PIX_W'(laplacian_at(w, h));
    r.last = 1'b0;
    if (out_col + 1 >= w) begin
      out_col = 0;
      out_sl = (out_sl + 1) % STORED_LINES;
      if (out_rw + 1 >= h) begin
        out_rw = 0;
        ahead = 1'b0;
        r.last = 1'b1;
      end else begin
        out_rw++;
      end
    end else begin
      out_col++;
    end
    expected_edges.push_back(r);
  endfunction

  // receiver with random idling and long hold-offs
  initial begin
    edges.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_left > 0) begin
        edges.ready <= 1'b0;
        stall_left--;
      end else begin
        edges.ready <= idle_on ? ($urandom_range(99) >= 31) : 1'b1;
      end
    end
  end

  // outputs are stable between edges, so sample the transfer at the falling edge
  always @(negedge clk) begin
    edge_result_t e;
    if (!rst && edges.valid && edges.ready) begin
      if (expected_edges.size() == 0) begin
        $error("unexpected output transfer: pixel_out %0d frame_end %0b",
               edges.pixel_out, edges.frame_end);
        fails++;
      end else begin
        e = expected_edges.pop_front();
        if (edges.pixel_out !== e.pixel) begin
          $error("pixel_out: expected %0d, actual %0d", e.pixel, edges.pixel_out);
          fails++;
        end
        if (edges.frame_end !== e.last) begin
          $error("frame_end: expected %0b, actual %0b", e.last, edges.frame_end);
          fails++;
        end
      end
    end
  end

  // entered just after a rising edge; returns at the edge of the transfer
  task automatic send_item(logic op, logic [PIX_W-1:0] pix);
    bit taken;
    while (idle_on && $urandom_range(99) < 31) begin
      pixels.valid <= 1'b0;
      pixels.op <= $urandom_range(1);
      pixels.pixel_in <= $urandom_range(255);
      @(posedge clk);
    end
    pixels.valid <= 1'b1;
    pixels.op <= op;
    pixels.pixel_in <= pix;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = pixels.ready;
      @(posedge clk);
    end
    predict_edge(op, pix);
  endtask

  task automatic drain_frame();
    while (ahead) send_item(OP_FLUSH, $urandom_range(255));
  endtask

  task automatic settle();
    drain_frame();
    pixels.valid <= 1'b0;
    while (expected_edges.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    settle();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(value);
    if (idx == CFG_LINE_WIDTH) reg_width = value & 12'h7FF;
    else reg_height = value & 12'hFFF;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // style 0 random, 1 checkerboard of extremes, 2 random extremes
  task automatic send_frame(int style, int flush_pct);
    int n, i;
    logic [PIX_W-1:0] p;
    n = eff_width() * eff_height();
    for (i = 0; i < n; i++) begin
      if ($urandom_range(99) < flush_pct) send_item(OP_FLUSH, $urandom_range(255));
      case (style)
        1: p = (((i % eff_width()) + (i / eff_width())) % 2) ? 8'hFF : 8'h00;
        2: p = $urandom_range(1) ? 8'hFF : 8'h00;
        default: p = $urandom_range(255);
      endcase
      send_item(OP_PIXEL, p);
    end
  endtask

  task automatic test_flush_before_frame_done();
    write_reg(CFG_LINE_WIDTH, 4);
    write_reg(CFG_FRAME_HEIGHT, 4);
    send_item(OP_FLUSH, 8'hFF);
    send_item(OP_FLUSH, 8'h00);
    send_frame(1, 0);
    drain_frame();
  endtask

  task automatic test_clamp_extremes();
    send_frame(2, 0);
    send_frame(1, 0);
    drain_frame();
  endtask

  // below the minimum, and top register bits beyond the field
  task automatic test_size_extremes();
    write_reg(CFG_LINE_WIDTH, 0);
    write_reg(CFG_FRAME_HEIGHT, 0);
    send_frame(0, 5);
    write_reg(CFG_LINE_WIDTH, 2052);
    write_reg(CFG_FRAME_HEIGHT, 3);
    send_frame(2, 0);
    settle();
  endtask

  task automatic test_back_pressure();
    write_reg(CFG_LINE_WIDTH, 8);
    write_reg(CFG_FRAME_HEIGHT, 8);
    stall_left = 400;
    send_frame(0, 0);
    drain_frame();
  endtask

  task automatic test_random_frames();
    int sent;
    sent = 0;
    idle_on = 1'b0;
    while (sent < 130) begin
      if (sent > 50) idle_on = 1'b1;
      write_reg(CFG_LINE_WIDTH, $urandom_range(4, 12));
      write_reg(CFG_FRAME_HEIGHT, $urandom_range(4, 9));
      repeat ($urandom_range(1, 3)) begin
        send_frame($urandom_range(3) == 0 ? 2 : 0, 8);
        sent += eff_width() * eff_height();
        if ($urandom_range(1)) drain_frame();
      end
    end
    settle();
  endtask

  initial begin
    fails = 0;
    cycles = 0;
    idle_on = 1'b1;
    stall_left = 0;
    cfg_we = 1'b0;
    cfg_index = CFG_LINE_WIDTH;
    cfg_data = '0;
    pixels.valid = 1'b0;
    pixels.op = OP_PIXEL;
    pixels.pixel_in = '0;
    in_col = 0; in_rw = 0; out_col = 0; out_rw = 0; in_sl = 0; out_sl = 0;
    ahead = 1'b0;
    reg_width = 960;
    reg_height = 540;
    rst = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_flush_before_frame_done();
    test_clamp_extremes();
    test_size_extremes();
    test_back_pressure();
    test_random_frames();
    settle();
    repeat (20) @(posedge clk);
    if (fails == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
